/* hdl/bnta_pkg.sv */
// shared types, constants and codes for the box novelty and text association block
package bnta_pkg;

    localparam int COORD_BITS        = 12;
    localparam int AREA_BITS         = 2 * COORD_BITS;
    localparam int UNI_BITS          = AREA_BITS + 1;
    localparam int FRAC_BITS         = 16;
    localparam int Q_BITS            = FRAC_BITS + 1;
    localparam int PROD_BITS         = Q_BITS + UNI_BITS;
    localparam int ELEM_BITS         = 9;
    localparam int HOST_BITS         = 8;
    localparam int CLASS_BITS        = 6;
    localparam int KIND_BITS         = 2;
    localparam int CFG_IDX_BITS      = 2;
    localparam int DEF_MAX_PROPOSALS = 256;
    localparam int DEF_MAX_TEXTS     = 256;

    localparam logic [KIND_BITS-1:0] KIND_MODEL = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_ICON  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_TEXT  = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_NOVELTY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CONTAIN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAME    = 2'd2;

    localparam logic [Q_BITS-1:0] RST_NOVELTY = 17'd32768;
    localparam logic [Q_BITS-1:0] RST_CONTAIN = 17'd52429;
    localparam logic [Q_BITS-1:0] RST_SAME    = 17'd52429;

    localparam logic [CLASS_BITS-1:0] LAST_INTERACTIVE_CLASS = 6'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } box_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic div_start;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic div_done;
        logic out_free;
        logic text_full;
    } sts_t;

endpackage

/* hdl/bnta_div.sv */
// restoring divider: Q1.16 floor of num/den for num <= den, one quotient bit per cycle
module bnta_div
    import bnta_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [AREA_BITS-1:0] num,
    input  logic [AREA_BITS-1:0] den,
    output logic                 done,
    output logic [Q_BITS-1:0]    quot
);

    localparam int RW = AREA_BITS + 2;
    localparam int CW = $clog2(Q_BITS + 1);

    logic [RW-1:0]        rem_reg;
    logic [AREA_BITS-1:0] den_reg;
    logic [Q_BITS-1:0]    quot_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [RW-1:0]        shifted;
    logic [RW-1:0]        diff;
    logic                 ge;

    // first step compares the unshifted remainder (integer bit of the quotient)
    assign shifted = (cnt_reg == CW'(Q_BITS)) ? rem_reg : {rem_reg[RW-2:0], 1'b0};
    assign ge      = shifted >= RW'(den_reg);
    assign diff    = shifted - RW'(den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(Q_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= RW'(num);
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff : shifted;
            quot_reg <= {quot_reg[Q_BITS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* hdl/bnta_ctrl.sv */
// controller: item sequencing, table scan addressing and result hand-off
module bnta_ctrl
    import bnta_pkg::*;
#(
    parameter int PW = 9
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [KIND_BITS-1:0] kind,
    input  sts_t                 sts,
    input  logic [PW-1:0]        ptot,
    output logic                 in_stall,
    output cmd_t                 cmd,
    output logic [PW-1:0]        scan_idx
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [PW-1:0]        cnt_reg, cnt_next;
    logic [KIND_BITS-1:0] kind_reg, kind_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    kind_next = kind;
                    cnt_next  = '0;
                    if (kind == KIND_ICON || (kind == KIND_TEXT && !sts.text_full))
                        state_next = ST_SCAN;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == ptot)
                    state_next = ST_DRAIN;
                else
                begin
                    cmd.scan = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    if (kind_reg == KIND_TEXT)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else
                        state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            kind_reg  <= KIND_MODEL;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign scan_idx = cnt_reg;

endmodule

/* hdl/bnta_dp.sv */
// datapath: proposal table, overlap pipeline, best-host tracking, totals and output word
module bnta_dp
    import bnta_pkg::*;
#(
    parameter int MAX_PROPOSALS = DEF_MAX_PROPOSALS,
    parameter int MAX_TEXTS     = DEF_MAX_TEXTS,
    parameter int PW            = $clog2(MAX_PROPOSALS + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    input  logic [PW-1:0]           scan_idx,
    input  logic [KIND_BITS-1:0]    kind,
    input  logic [COORD_BITS-1:0]   box_x,
    input  logic [COORD_BITS-1:0]   box_y,
    input  logic [COORD_BITS-1:0]   box_w,
    input  logic [COORD_BITS-1:0]   box_h,
    input  logic [CLASS_BITS-1:0]   class_code,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [Q_BITS-1:0]       cfg_data,
    input  logic                    out_stall,
    output sts_t                    sts,
    output logic [PW-1:0]           ptot,
    output logic                    out_valid,
    output logic [ELEM_BITS-1:0]    element_index,
    output logic                    accepted,
    output logic                    interactive,
    output logic                    associated,
    output logic [HOST_BITS-1:0]    host_index,
    output logic [Q_BITS-1:0]       match_score,
    output logic                    relation,
    output logic                    status
);

    localparam int TW  = $clog2(MAX_TEXTS + 1);
    localparam int AW  = $clog2(MAX_PROPOSALS);
    localparam int SW  = ((PW > TW) ? PW : TW) + 1;
    localparam int EW  = (SW > ELEM_BITS) ? SW : ELEM_BITS;
    localparam int HW  = (AW > HOST_BITS) ? AW : HOST_BITS;
    localparam int CBW = AREA_BITS + 3;

    function automatic logic [COORD_BITS-1:0] span(
        input logic [COORD_BITS-1:0] a_pos,
        input logic [COORD_BITS-1:0] a_len,
        input logic [COORD_BITS-1:0] b_pos,
        input logic [COORD_BITS-1:0] b_len
    );
        logic [COORD_BITS:0] lo;
        logic [COORD_BITS:0] a_end;
        logic [COORD_BITS:0] b_end;
        logic [COORD_BITS:0] hi;
        lo    = (a_pos > b_pos) ? {1'b0, a_pos} : {1'b0, b_pos};
        a_end = {1'b0, a_pos} + {1'b0, a_len};
        b_end = {1'b0, b_pos} + {1'b0, b_len};
        hi    = (a_end < b_end) ? a_end : b_end;
        span  = (hi > lo) ? COORD_BITS'(hi - lo) : '0;
    endfunction

    // configuration
    logic [Q_BITS-1:0] nov_reg, con_reg, same_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nov_reg  <= RST_NOVELTY;
            con_reg  <= RST_CONTAIN;
            same_reg <= RST_SAME;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NOVELTY: nov_reg  <= cfg_data;
                REG_CONTAIN: con_reg  <= cfg_data;
                REG_SAME:    same_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // item under work
    box_t                  item_reg;
    logic [CLASS_BITS-1:0] cls_reg;
    logic [KIND_BITS-1:0]  kind_reg;
    logic [AREA_BITS-1:0]  area_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= '{x: box_x, y: box_y, w: box_w, h: box_h};
            cls_reg  <= class_code;
            kind_reg <= kind;
            area_reg <= AREA_BITS'(box_w) * AREA_BITS'(box_h);
        end
    end

    // proposal table
    box_t           mem [MAX_PROPOSALS];
    logic           wr_en;
    logic [PW-1:0]  ptot_reg, ptot_next;
    logic [TW-1:0]  ttot_reg, ttot_next;
    box_t           rd_reg;
    logic [AW-1:0]  idx1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[ptot_reg[AW-1:0]] <= item_reg;
        if (cmd.scan)
        begin
            rd_reg   <= mem[scan_idx[AW-1:0]];
            idx1_reg <= scan_idx[AW-1:0];
        end
    end

    // overlap pipeline, one stored box per cycle
    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [COORD_BITS-1:0] dx2_reg, dy2_reg, pw2_reg, ph2_reg;
    logic [AW-1:0]         idx2_reg, idx3_reg, idx4_reg, idx5_reg;
    logic [AREA_BITS-1:0]  inter3_reg, pa3_reg, inter4_reg, pa4_reg, inter5_reg, pa5_reg;
    logic [UNI_BITS-1:0]   uni3, den4_reg;
    logic [CBW-1:0]        cover5x, area4x;
    logic                  con4_reg, con5_reg, dz5_reg;
    logic [Q_BITS-1:0]     thr;
    logic [PROD_BITS-1:0]  prod5_reg;
    logic                  hit;

    assign thr     = (kind_reg == KIND_ICON) ? nov_reg : con_reg;
    assign uni3    = UNI_BITS'(area_reg) + UNI_BITS'(pa3_reg) - UNI_BITS'(inter3_reg);
    assign cover5x = (CBW'(inter3_reg) << 2) + CBW'(inter3_reg);
    assign area4x  = CBW'(area_reg) << 2;
    assign hit     = dz5_reg ? (thr == '0)
                             : (PROD_BITS'({inter5_reg, FRAC_BITS'(0)}) >= prod5_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx2_reg    <= span(item_reg.x, item_reg.w, rd_reg.x, rd_reg.w);
        dy2_reg    <= span(item_reg.y, item_reg.h, rd_reg.y, rd_reg.h);
        pw2_reg    <= rd_reg.w;
        ph2_reg    <= rd_reg.h;
        idx2_reg   <= idx1_reg;
        inter3_reg <= AREA_BITS'(dx2_reg) * AREA_BITS'(dy2_reg);
        pa3_reg    <= AREA_BITS'(pw2_reg) * AREA_BITS'(ph2_reg);
        idx3_reg   <= idx2_reg;
        inter4_reg <= inter3_reg;
        pa4_reg    <= pa3_reg;
        den4_reg   <= (kind_reg == KIND_TEXT) ? UNI_BITS'(area_reg) : uni3;
        // icon mostly inside a stored box: more than four fifths covered
        con4_reg   <= (area_reg != '0) && (cover5x > area4x);
        idx4_reg   <= idx3_reg;
        prod5_reg  <= PROD_BITS'(thr) * PROD_BITS'(den4_reg);
        dz5_reg    <= (den4_reg == '0);
        inter5_reg <= inter4_reg;
        pa5_reg    <= pa4_reg;
        con5_reg   <= con4_reg;
        idx5_reg   <= idx4_reg;
    end

    // scan results
    logic                 reject_reg, found_reg;
    logic [AW-1:0]        best_idx_reg;
    logic [AREA_BITS-1:0] host_area_reg, best_inter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reject_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            reject_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else if (v5_reg)
        begin
            reject_reg <= reject_reg | hit | con5_reg;
            if (hit && (!found_reg || pa5_reg < host_area_reg))
                found_reg <= 1'b1;
        end
    end

    // strict less-than keeps the earliest box on equal area
    always_ff @(posedge clk)
    begin
        if (v5_reg && hit && (!found_reg || pa5_reg < host_area_reg))
        begin
            best_idx_reg   <= idx5_reg;
            host_area_reg  <= pa5_reg;
            best_inter_reg <= inter5_reg;
        end
    end

    // score and relation of the chosen host
    logic [UNI_BITS-1:0]  uni_b;
    logic [PROD_BITS-1:0] prodf_reg;
    logic                 rel;
    logic                 div_done;
    logic [Q_BITS-1:0]    quot;

    assign uni_b = UNI_BITS'(host_area_reg) + UNI_BITS'(area_reg) - UNI_BITS'(best_inter_reg);
    assign rel   = (uni_b == '0) ? (same_reg == '0)
                                 : (PROD_BITS'({best_inter_reg, FRAC_BITS'(0)}) >= prodf_reg);

    always_ff @(posedge clk)
    begin
        prodf_reg <= PROD_BITS'(same_reg) * PROD_BITS'(uni_b);
    end

    // cover fraction never falls below IoU, so it alone is the score
    bnta_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (best_inter_reg),
        .den   (area_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // result word
    logic                 p_full, t_full;
    logic                 store, tinc, clr;
    logic [EW-1:0]        sum_e;
    logic [HW-1:0]        host_e;
    logic [ELEM_BITS-1:0] r_elem;
    logic                 r_acc, r_int, r_assoc, r_rel, r_status;
    logic [HOST_BITS-1:0] r_host;
    logic [Q_BITS-1:0]    r_score;

    assign p_full = ptot_reg >= PW'(MAX_PROPOSALS);
    assign t_full = ttot_reg >= TW'(MAX_TEXTS);
    assign sum_e  = EW'(ptot_reg) + EW'(ttot_reg);
    assign host_e = HW'(best_idx_reg);

    always_comb
    begin
        store    = 1'b0;
        tinc     = 1'b0;
        clr      = 1'b0;
        r_elem   = '0;
        r_acc    = 1'b0;
        r_int    = 1'b0;
        r_assoc  = 1'b0;
        r_host   = '0;
        r_score  = '0;
        r_rel    = 1'b0;
        r_status = 1'b0;
        unique case (kind_reg)
            KIND_CLEAR:
                clr = 1'b1;
            KIND_MODEL:
            begin
                r_int = (cls_reg <= LAST_INTERACTIVE_CLASS);
                if (p_full)
                    r_status = 1'b1;
                else
                    store = 1'b1;
            end
            KIND_ICON:
            begin
                r_int = 1'b1;
                if (!reject_reg)
                begin
                    if (p_full)
                        r_status = 1'b1;
                    else
                        store = 1'b1;
                end
            end
            KIND_TEXT:
            begin
                if (t_full)
                    r_status = 1'b1;
                else
                begin
                    tinc   = 1'b1;
                    r_elem = sum_e[ELEM_BITS-1:0];
                    if (found_reg)
                    begin
                        r_assoc = 1'b1;
                        r_host  = host_e[HOST_BITS-1:0];
                        r_score = (area_reg == '0) ? '0 : quot;
                        r_rel   = rel;
                    end
                end
            end
            default: ;
        endcase
        if (store)
        begin
            r_elem = ELEM_BITS'(ptot_reg);
            r_acc  = 1'b1;
        end
    end

    assign wr_en = cmd.finish & store;

    always_comb
    begin
        ptot_next = ptot_reg;
        ttot_next = ttot_reg;
        if (cmd.finish)
        begin
            if (clr)
            begin
                ptot_next = '0;
                ttot_next = '0;
            end
            else
            begin
                if (store)
                    ptot_next = ptot_reg + 1'b1;
                if (tinc)
                    ttot_next = ttot_reg + 1'b1;
            end
        end
    end

    logic                 out_valid_reg;
    logic [ELEM_BITS-1:0] elem_reg;
    logic                 acc_reg, int_reg, assoc_reg, rel_reg, status_reg;
    logic [HOST_BITS-1:0] host_reg;
    logic [Q_BITS-1:0]    score_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptot_reg      <= '0;
            ttot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ptot_reg <= ptot_next;
            ttot_reg <= ttot_next;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            elem_reg   <= r_elem;
            acc_reg    <= r_acc;
            int_reg    <= r_int;
            assoc_reg  <= r_assoc;
            host_reg   <= r_host;
            score_reg  <= r_score;
            rel_reg    <= r_rel;
            status_reg <= r_status;
        end
    end

    assign sts = '{pipe_busy: v1_reg | v2_reg | v3_reg | v4_reg | v5_reg,
                   div_done:  div_done,
                   out_free:  !out_valid_reg || !out_stall,
                   text_full: t_full};

    assign ptot          = ptot_reg;
    assign out_valid     = out_valid_reg;
    assign element_index = elem_reg;
    assign accepted      = acc_reg;
    assign interactive   = int_reg;
    assign associated    = assoc_reg;
    assign host_index    = host_reg;
    assign match_score   = score_reg;
    assign relation      = rel_reg;
    assign status        = status_reg;

endmodule

/* hdl/box_novelty_and_text_association.sv */
// model box and clear frame skip the scan and give their word once the output is free
// icon box: the N stored proposals are streamed one per cycle through the overlap pipeline
// text box: the scan, then the bit-serial score divider, before the word is given
// one item in flight; the next is taken while the last word waits
// reset: totals cleared, thresholds to defaults; table contents are undefined until written
// top level of the box novelty and text association block
module box_novelty_and_text_association
    import bnta_pkg::*;
#(
    parameter int MAX_PROPOSALS = DEF_MAX_PROPOSALS,
    parameter int MAX_TEXTS     = DEF_MAX_TEXTS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [KIND_BITS-1:0]    kind,
    input  logic [COORD_BITS-1:0]   box_x,
    input  logic [COORD_BITS-1:0]   box_y,
    input  logic [COORD_BITS-1:0]   box_w,
    input  logic [COORD_BITS-1:0]   box_h,
    input  logic [CLASS_BITS-1:0]   class_code,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [Q_BITS-1:0]       cfg_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [ELEM_BITS-1:0]    element_index,
    output logic                    accepted,
    output logic                    interactive,
    output logic                    associated,
    output logic [HOST_BITS-1:0]    host_index,
    output logic [Q_BITS-1:0]       match_score,
    output logic                    relation,
    output logic                    status
);

    localparam int PW = $clog2(MAX_PROPOSALS + 1);

    cmd_t          cmd;
    sts_t          sts;
    logic [PW-1:0] ptot;
    logic [PW-1:0] scan_idx;

    assign cfg_ready = 1'b1;

    bnta_ctrl #(
        .PW (PW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .sts      (sts),
        .ptot     (ptot),
        .in_stall (in_stall),
        .cmd      (cmd),
        .scan_idx (scan_idx)
    );

    bnta_dp #(
        .MAX_PROPOSALS (MAX_PROPOSALS),
        .MAX_TEXTS     (MAX_TEXTS),
        .PW            (PW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .scan_idx      (scan_idx),
        .kind          (kind),
        .box_x         (box_x),
        .box_y         (box_y),
        .box_w         (box_w),
        .box_h         (box_h),
        .class_code    (class_code),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_stall     (out_stall),
        .sts           (sts),
        .ptot          (ptot),
        .out_valid     (out_valid),
        .element_index (element_index),
        .accepted      (accepted),
        .interactive   (interactive),
        .associated    (associated),
        .host_index    (host_index),
        .match_score   (match_score),
        .relation      (relation),
        .status        (status)
    );

endmodule

/* hdl/bnta_check.sv */
// port-level checker for the box novelty and text association block, with its bind
module bnta_check
    import bnta_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [ELEM_BITS-1:0] element_index,
    input logic                 accepted,
    input logic                 interactive,
    input logic                 associated,
    input logic [HOST_BITS-1:0] host_index,
    input logic [Q_BITS-1:0]    match_score,
    input logic                 relation,
    input logic                 status
);

    // a held word keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(element_index) && $stable(status)
            && $stable(match_score) && $stable(host_index))
        else $error("output word changed while stalled");

    // one item at a time: taking a word closes the input in the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on consecutive cycles");

    a_store_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> !status && !associated)
        else $error("stored box flagged as dropped or associated");

    a_no_host: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !associated |-> host_index == '0 && match_score == '0 && !relation)
        else $error("host fields set without association");

    a_text_host: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && associated |-> !interactive && !status)
        else $error("associated text with stray flags");

endmodule

bind box_novelty_and_text_association bnta_check u_bnta_check (.*);

/* sim/bnta_checker.sv */
// checker: predicts each word of the association block and compares it on the output channel
`timescale 1ns / 100ps

module bnta_checker
    import bnta_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [KIND_BITS-1:0]    kind,
    input  logic [COORD_BITS-1:0]   box_x,
    input  logic [COORD_BITS-1:0]   box_y,
    input  logic [COORD_BITS-1:0]   box_w,
    input  logic [COORD_BITS-1:0]   box_h,
    input  logic [CLASS_BITS-1:0]   class_code,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [Q_BITS-1:0]       cfg_data,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [ELEM_BITS-1:0]    element_index,
    input  logic                    accepted,
    input  logic                    interactive,
    input  logic                    associated,
    input  logic [HOST_BITS-1:0]    host_index,
    input  logic [Q_BITS-1:0]       match_score,
    input  logic                    relation,
    input  logic                    status,
    output int                      errors,
    output int                      pending,
    output int                      words_seen
);

    localparam int PROP_LIMIT = DEF_MAX_PROPOSALS;
    localparam int TEXT_LIMIT = DEF_MAX_TEXTS;

    typedef struct {
        longint unsigned x, y, w, h;
    } rect_t;

    typedef struct packed {
        logic [ELEM_BITS-1:0] elem;
        logic                 acc;
        logic                 inter;
        logic                 assoc;
        logic [HOST_BITS-1:0] host;
        logic [Q_BITS-1:0]    score;
        logic                 rel;
        logic                 full;
    } word_t;

    rect_t       stored_boxes [PROP_LIMIT];
    int unsigned stored_count;
    int unsigned text_count;
    logic [Q_BITS-1:0] thr_novel, thr_contain, thr_same;
    word_t       expected_words [$];

    function automatic longint unsigned overlap(rect_t a, rect_t b);
        longint unsigned l, t, r, bo;
        l  = (a.x > b.x) ? a.x : b.x;
        t  = (a.y > b.y) ? a.y : b.y;
        r  = (a.x + a.w < b.x + b.w) ? a.x + a.w : b.x + b.w;
        bo = (a.y + a.h < b.y + b.h) ? a.y + a.h : b.y + b.h;
        if (r <= l || bo <= t)
            return 0;
        return (r - l) * (bo - t);
    endfunction

    // exact num/den >= thr/2^16, zero denominator counts as ratio zero
    function automatic bit at_least(longint unsigned num, longint unsigned den,
                                    longint unsigned thr);
        if (den == 0)
            return thr == 0;
        return (num << 16) >= thr * den;
    endfunction

    function automatic longint unsigned q16(longint unsigned num, longint unsigned den);
        if (den == 0)
            return 0;
        return (num << 16) / den;
    endfunction

    task automatic associate_box(input logic [KIND_BITS-1:0] k, input rect_t b,
                                 input logic [CLASS_BITS-1:0] cls, output word_t res);
        longint unsigned a, ov, uni, pa, min_area, best_ov, cq, iq;
        int unsigned best;
        bit found;
        res = '0;
        a = b.w * b.h;
        if (k == KIND_CLEAR) begin
            stored_count = 0;
            text_count = 0;
            return;
        end
        if (k == KIND_MODEL || k == KIND_ICON) begin
            if (k == KIND_MODEL) begin
                res.inter = (cls <= LAST_INTERACTIVE_CLASS);
            end
            else begin
                res.inter = 1'b1;
                for (int i = 0; i < stored_count; i++) begin
                    ov = overlap(b, stored_boxes[i]);
                    uni = a + stored_boxes[i].w * stored_boxes[i].h - ov;
                    if (at_least(ov, uni, thr_novel))
                        return;
                    if (a > 0 && 5 * ov > 4 * a)
                        return;
                end
            end
            if (stored_count >= PROP_LIMIT) begin
                res.full = 1'b1;
                return;
            end
            stored_boxes[stored_count] = b;
            res.elem = stored_count[ELEM_BITS-1:0];
            res.acc = 1'b1;
            stored_count++;
            return;
        end
        if (text_count >= TEXT_LIMIT) begin
            res.full = 1'b1;
            return;
        end
        res.elem = ELEM_BITS'(stored_count + text_count);
        text_count++;
        found = 0;
        best = 0;
        min_area = 0;
        best_ov = 0;
        for (int i = 0; i < stored_count; i++) begin
            ov = overlap(b, stored_boxes[i]);
            if (!at_least(ov, a, thr_contain))
                continue;
            pa = stored_boxes[i].w * stored_boxes[i].h;
            if (!found || pa < min_area) begin
                found = 1;
                best = i;
                min_area = pa;
                best_ov = ov;
            end
        end
        if (found) begin
            uni = min_area + a - best_ov;
            cq = q16(best_ov, a);
            iq = q16(best_ov, uni);
            res.assoc = 1'b1;
            res.host = best[HOST_BITS-1:0];
            res.score = Q_BITS'((cq > iq) ? cq : iq);
            res.rel = at_least(best_ov, uni, thr_same);
        end
    endtask

    task automatic report(input string field, input longint unsigned got,
                          input longint unsigned want);
        $display("mismatch on word %0d: %s got %0d expected %0d", words_seen, field, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        word_t w;
        rect_t b;
        if (!rst_n) begin
            stored_count = 0;
            text_count = 0;
            thr_novel = RST_NOVELTY;
            thr_contain = RST_CONTAIN;
            thr_same = RST_SAME;
            expected_words.delete();
            errors = 0;
            words_seen = 0;
            pending = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NOVELTY: thr_novel = cfg_data;
                    REG_CONTAIN: thr_contain = cfg_data;
                    REG_SAME:    thr_same = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    report("out_valid without a pending item", 1, 0);
                end
                else begin
                    w = expected_words.pop_front();
                    if (element_index !== w.elem) report("element_index", element_index, w.elem);
                    if (accepted !== w.acc) report("accepted", accepted, w.acc);
                    if (interactive !== w.inter) report("interactive", interactive, w.inter);
                    if (associated !== w.assoc) report("associated", associated, w.assoc);
                    if (host_index !== w.host) report("host_index", host_index, w.host);
                    if (match_score !== w.score) report("match_score", match_score, w.score);
                    if (relation !== w.rel) report("relation", relation, w.rel);
                    if (status !== w.full) report("status", status, w.full);
                end
                words_seen++;
            end
            if (in_valid && !in_stall) begin
                b.x = box_x;
                b.y = box_y;
                b.w = box_w;
                b.h = box_h;
                associate_box(kind, b, class_code, w);
                expected_words = {expected_words, w};
            end
            pending = expected_words.size();
        end
    end

endmodule

/* sim/testbench.sv */
// testbench top: stimulus, configuration phases and verdict for the association block
`timescale 1ns / 100ps

module testbench;
    import bnta_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [KIND_BITS-1:0]    kind;
    logic [COORD_BITS-1:0]   box_x, box_y, box_w, box_h;
    logic [CLASS_BITS-1:0]   class_code;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [Q_BITS-1:0]       cfg_data;
    logic                    out_valid;
    logic                    out_stall;
    logic [ELEM_BITS-1:0]    element_index;
    logic                    accepted, interactive, associated, relation, status;
    logic [HOST_BITS-1:0]    host_index;
    logic [Q_BITS-1:0]       match_score;
    int                      errors, pending, words_seen;

    typedef struct {
        int x, y, w, h;
    } area_t;

    area_t frame_boxes [$];
    int    burst_left;
    int    items_sent;
    int    stall_mode;
    int    stall_cnt;

    box_novelty_and_text_association dut (.*);
    bnta_checker u_scoreboard (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d words still expected", pending);
        $display("[box_novelty_and_text_association] ERROR");
        $finish;
    end

    // receiver stall follows a randomly chosen mode: none, light, heavy or periodic
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            stall_cnt  <= 0;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt % 600 == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 25);
                2: out_stall <= ($urandom_range(0, 99) < 70);
                default: out_stall <= (stall_cnt % 7 < 3);
            endcase
        end
    end

    task automatic send_word(input logic [KIND_BITS-1:0] k, input int x, input int y,
                             input int w, input int h, input int cls);
        area_t r;
        bit    taken;
        in_valid   <= 1'b1;
        kind       <= k;
        box_x      <= x[COORD_BITS-1:0];
        box_y      <= y[COORD_BITS-1:0];
        box_w      <= w[COORD_BITS-1:0];
        box_h      <= h[COORD_BITS-1:0];
        class_code <= cls[CLASS_BITS-1:0];
        // stall is settled at the falling edge ahead of the edge that takes the word
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
        if (k == KIND_CLEAR)
            frame_boxes.delete();
        else if (k != KIND_TEXT)
        begin
            r.x = x % 4096;
            r.y = y % 4096;
            r.w = w % 4096;
            r.h = h % 4096;
            frame_boxes = {frame_boxes, r};
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[Q_BITS-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_thresholds(input int nov, input int con, input int same);
        drain();
        write_reg(REG_NOVELTY, nov);
        write_reg(REG_CONTAIN, con);
        write_reg(REG_SAME, same);
        cfg_valid <= 1'b0;
    endtask

    // mostly small boxes in a crowded region so that overlaps are common
    task automatic pick_box(output int x, output int y, output int w, output int h);
        area_t p;
        int m;
        m = $urandom_range(0, 99);
        if (m < 6)
        begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
            w = $urandom_range(0, 4095);
            h = $urandom_range(0, 4095);
        end
        else if (m < 45 && frame_boxes.size() > 0)
        begin
            // near copy of a stored box
            p = frame_boxes[$urandom_range(0, frame_boxes.size() - 1)];
            x = p.x + $urandom_range(0, 6);
            y = p.y + $urandom_range(0, 6);
            w = (p.w > 3) ? p.w - $urandom_range(0, 3) : p.w;
            h = (p.h > 3) ? p.h - $urandom_range(0, 3) : p.h;
        end
        else
        begin
            x = $urandom_range(0, 300);
            y = $urandom_range(0, 300);
            w = $urandom_range(0, 120);
            h = $urandom_range(0, 120);
        end
    endtask

    task automatic pick_text(output int x, output int y, output int w, output int h);
        area_t p;
        if (frame_boxes.size() == 0 || $urandom_range(0, 4) == 0)
            pick_box(x, y, w, h);
        else
        begin
            p = frame_boxes[$urandom_range(0, frame_boxes.size() - 1)];
            x = p.x + $urandom_range(0, p.w / 2);
            y = p.y + $urandom_range(0, p.h / 2);
            w = $urandom_range(0, p.w / 2 + 2);
            h = $urandom_range(0, p.h / 2 + 2);
        end
    endtask

    task automatic random_frames(input int count);
        int x, y, w, h, n, r, stop;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            send_word(KIND_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 63));
            n = $urandom_range(4, 30);
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                begin
                    pick_box(x, y, w, h);
                    send_word(KIND_MODEL, x, y, w, h, $urandom_range(0, 63));
                end
                else if (r < 60)
                begin
                    pick_box(x, y, w, h);
                    send_word(KIND_ICON, x, y, w, h, $urandom_range(0, 63));
                end
                else if (r < 98)
                begin
                    pick_text(x, y, w, h);
                    send_word(KIND_TEXT, x, y, w, h, $urandom_range(0, 63));
                end
                else
                    send_word(KIND_CLEAR, 0, 0, 0, 0, 0);
            end
        end
    endtask

    initial
    begin
        int nov, con;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_CLEAR;
        box_x      = '0;
        box_y      = '0;
        box_w      = '0;
        box_h      = '0;
        class_code = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_NOVELTY;
        cfg_data   = '0;
        burst_left = 0;
        items_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: classes, duplicates, containment, extremes, zero area, no host
        send_word(KIND_TEXT, 10, 10, 5, 5, 0);
        send_word(KIND_MODEL, 100, 100, 50, 50, 0);
        send_word(KIND_MODEL, 300, 300, 80, 40, 3);
        send_word(KIND_MODEL, 0, 0, 4095, 4095, 4);
        send_word(KIND_MODEL, 4095, 4095, 4095, 4095, 63);
        send_word(KIND_ICON, 100, 100, 50, 50, 63);
        send_word(KIND_ICON, 110, 110, 30, 30, 0);
        send_word(KIND_ICON, 600, 600, 10, 10, 0);
        send_word(KIND_ICON, 600, 600, 0, 0, 0);
        send_word(KIND_TEXT, 110, 110, 20, 20, 0);
        send_word(KIND_TEXT, 100, 100, 50, 50, 0);
        send_word(KIND_TEXT, 120, 120, 0, 7, 0);
        send_word(KIND_TEXT, 3000, 50, 10, 10, 0);
        send_word(KIND_TEXT, 4095, 4095, 4095, 4095, 63);
        send_word(KIND_MODEL, 112, 112, 16, 16, 2);
        send_word(KIND_TEXT, 113, 113, 10, 10, 0);
        send_word(KIND_CLEAR, 4095, 4095, 4095, 4095, 63);
        send_word(KIND_TEXT, 113, 113, 10, 10, 0);
        send_word(KIND_ICON, 0, 0, 0, 0, 0);

        set_thresholds(0, 0, 0);
        send_word(KIND_CLEAR, 0, 0, 0, 0, 0);
        send_word(KIND_MODEL, 50, 50, 10, 10, 1);
        send_word(KIND_ICON, 900, 900, 10, 10, 1);
        send_word(KIND_TEXT, 2000, 2000, 0, 0, 0);
        random_frames(250);

        // full proposal table, then full text count
        set_thresholds(65536, 65536, 65536);
        send_word(KIND_CLEAR, 0, 0, 0, 0, 0);
        for (int i = 0; i < 258; i++)
            send_word(KIND_MODEL, (i * 13) % 4000, (i * 7) % 4000, 9, 9, i);
        send_word(KIND_ICON, 4000, 4000, 5, 5, 0);
        send_word(KIND_TEXT, 0, 0, 9, 9, 0);
        send_word(KIND_CLEAR, 0, 0, 0, 0, 0);
        send_word(KIND_MODEL, 10, 10, 20, 20, 5);
        for (int i = 0; i < 258; i++)
            send_word(KIND_TEXT, 10 + i % 8, 10 + i % 5, i % 20, 6, 0);
        random_frames(200);

        set_thresholds(131071, 65535, 1);
        random_frames(250);
        set_thresholds(RST_NOVELTY, RST_CONTAIN, RST_SAME);
        random_frames(300);
        repeat (2)
        begin
            nov = $urandom_range(0, 65536);
            con = $urandom_range(0, 65536);
            set_thresholds(nov, con, $urandom_range(0, 65536));
            random_frames(200);
        end

        drain();
        repeat (60) @(posedge clk);
        $display("sent %0d items over six threshold settings, %0d result words checked",
                 items_sent, words_seen);
        $display("frames covered full proposal table, full text count and late boxes");
        if (errors == 0 && pending == 0)
            $display("[box_novelty_and_text_association] OK");
        else
            $display("[box_novelty_and_text_association] ERROR");
        $finish;
    end

endmodule

/* sim.f */
hdl/bnta_pkg.sv
hdl/bnta_div.sv
hdl/bnta_ctrl.sv
hdl/bnta_dp.sv
hdl/box_novelty_and_text_association.sv
hdl/bnta_check.sv
sim/bnta_checker.sv
sim/testbench.sv
